// ===== hdl/ascs_pkg.sv =====
// ----------------------------------------------------------------------------
// ascs_pkg
// Shared types, constants and the sine table for the arm span angle search.
// ----------------------------------------------------------------------------
package ascs_pkg;

	// Angle constants, degrees
	localparam logic [7:0] CENTRE_DEG  = 8'd90;
	localparam logic [7:0] TOP_DEG     = 8'd180;
	localparam logic [6:0] SEARCH_STEP = 7'd2;

	// Table scaling and default trig precision
	localparam int TABLE_FRAC          = 15;
	localparam int TRIG_FRAC_BITS_DEF  = 15;

	// Signed width of a tip-to-tip span component (covers +/- 3 * 65535)
	localparam int SPAN_W = 19;

	// Register indexes
	localparam logic [1:0] REG_TIP_REACH        = 2'd0;
	localparam logic [1:0] REG_PIVOT_SEPARATION = 2'd1;
	localparam logic [1:0] REG_MIN_SPAN         = 2'd2;
	localparam logic [1:0] REG_MAX_SPAN         = 2'd3;

	// Register reset values, Q8.8 centimetres
	localparam logic [15:0] TIP_REACH_RST        = 16'd4096;
	localparam logic [15:0] PIVOT_SEPARATION_RST = 16'd6400;
	localparam logic [15:0] MIN_SPAN_RST         = 16'd1280;
	localparam logic [15:0] MAX_SPAN_RST         = 16'd6400;

	typedef enum logic [1:0] {
		OUTCOME_KEPT     = 2'd0,
		OUTCOME_MOVED    = 2'd1,
		OUTCOME_FALLBACK = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [15:0] tip_reach;
		logic [15:0] pivot_separation;
		logic [15:0] min_span;
		logic [15:0] max_span;
	} cfg_t;

	typedef struct packed {
		logic       start;
		logic [7:0] a1;
		logic [7:0] a2;
	} span_req_t;

	typedef struct packed {
		logic done;
		logic ok;
	} span_rsp_t;

	localparam logic [15:0] SINE_Q15 [0:90] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	// Sine of a whole degree 0..90, Q1.15; anything above 90 reads as 90
	function automatic logic [15:0] sine_q15(input logic [6:0] deg);
		logic [15:0] v;
		if (deg > 7'd90) begin
			v = SINE_Q15[90];
		end else begin
			v = SINE_Q15[deg];
		end
		return v;
	endfunction

	// Clamp an angle to 0..180
	function automatic logic [7:0] sat_angle(input logic [7:0] a);
		return (a > TOP_DEG) ? TOP_DEG : a;
	endfunction

endpackage

// ===== hdl/ascs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ascs_cmd_if
// Valid/ready channel carrying one pair of servo angles.
// ----------------------------------------------------------------------------
interface ascs_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_angle;
	logic [7:0] wanted_second_angle;

	modport source (output valid, output first_angle, output wanted_second_angle,
		input ready);
	modport sink (input valid, input first_angle, input wanted_second_angle,
		output ready);
endinterface

// ===== hdl/ascs_rsl_if.sv =====
// ----------------------------------------------------------------------------
// ascs_rsl_if
// Valid/ready channel carrying the permitted second angle and its outcome.
// ----------------------------------------------------------------------------
interface ascs_rsl_if;
	logic       valid;
	logic       ready;
	logic [7:0] second_angle;
	logic [1:0] outcome;

	modport source (output valid, output second_angle, output outcome, input ready);
	modport sink (input valid, input second_angle, input outcome, output ready);
endinterface

// ===== hdl/ascs_span_unit.sv =====
// ----------------------------------------------------------------------------
// ascs_span_unit
// Tests one angle pair: squared tip span against min and max, one shared
// multiplier stepped through by a small sequencer.
// ----------------------------------------------------------------------------
module ascs_span_unit #(
	parameter int TRIG_FRAC_BITS = ascs_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ascs_pkg::cfg_t    cfg,
	input  ascs_pkg::span_req_t req,
	output ascs_pkg::span_rsp_t rsp
);
	import ascs_pkg::*;

	localparam int TV_W    = TRIG_FRAC_BITS + 1;
	localparam int DIFF_W  = TV_W + 2;
	localparam int MUL_W   = (DIFF_W > SPAN_W) ? DIFF_W : SPAN_W;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SQ_W    = 2 * SPAN_W;
	localparam int UP      = (TRIG_FRAC_BITS >= TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
	localparam int DN      = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
	localparam int TMP_W   = TV_W + 17;
	localparam logic [TMP_W-1:0] TAB_HALF = (DN > 0) ? (TMP_W'(1) << (DN - 1)) : '0;
	localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) << (TRIG_FRAC_BITS - 1);

	typedef enum logic [3:0] {
		U_IDLE, U_DIFF, U_MX, U_MY, U_SX, U_SY, U_LO, U_HI, U_CMP
	} ustate_t;

	ustate_t                   state_q;
	logic [7:0]                a1_q, a2_q;
	logic signed [DIFF_W-1:0]  ds_q, dc_q;
	logic signed [SPAN_W-1:0]  dx_q, dy_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]           sum_q;
	logic                      lo_ok_q;

	logic signed [MUL_W-1:0]   op_a, op_b;
	logic signed [DIFF_W-1:0]  ds_d, dc_d;
	logic signed [SPAN_W-1:0]  rnd, piv_ext;
	logic [SQ_W-1:0]           prod_lo;

	// Table entry rescaled to TRIG_FRAC_BITS, rounding half up when narrower
	function automatic logic [TV_W-1:0] trig_val(input logic [6:0] deg);
		logic [TMP_W-1:0] v;
		v = TMP_W'(sine_q15(deg));
		v = v << UP;
		v = (v + TAB_HALF) >> DN;
		return TV_W'(v);
	endfunction

	function automatic logic signed [DIFF_W-1:0] sin_of(input logic [7:0] a);
		logic [6:0] idx;
		idx = (a <= CENTRE_DEG) ? a[6:0] : 7'(TOP_DEG - a);
		return DIFF_W'({1'b0, trig_val(idx)});
	endfunction

	function automatic logic signed [DIFF_W-1:0] cos_of(input logic [7:0] a);
		logic signed [DIFF_W-1:0] m;
		m = (a <= CENTRE_DEG) ? DIFF_W'({1'b0, trig_val(7'(CENTRE_DEG - a))})
		                      : DIFF_W'({1'b0, trig_val(7'(a - CENTRE_DEG))});
		return (a <= CENTRE_DEG) ? m : -m;
	endfunction

	assign ds_d    = sin_of(a2_q) - sin_of(a1_q);
	assign dc_d    = cos_of(a1_q) - cos_of(a2_q);
	assign rnd     = SPAN_W'((prod_q + RND_BIAS) >>> TRIG_FRAC_BITS);
	assign piv_ext = SPAN_W'({1'b0, cfg.pivot_separation});
	assign prod_lo = SQ_W'(prod_q);

	// Operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			U_MX: begin
				op_a = MUL_W'({1'b0, cfg.tip_reach});
				op_b = MUL_W'(ds_q);
			end
			U_MY: begin
				op_a = MUL_W'({1'b0, cfg.tip_reach});
				op_b = MUL_W'(dc_q);
			end
			U_SX: begin
				op_a = MUL_W'(dx_q);
				op_b = MUL_W'(dx_q);
			end
			U_SY: begin
				op_a = MUL_W'(dy_q);
				op_b = MUL_W'(dy_q);
			end
			U_LO: begin
				op_a = MUL_W'({1'b0, cfg.min_span});
				op_b = MUL_W'({1'b0, cfg.min_span});
			end
			U_HI: begin
				op_a = MUL_W'({1'b0, cfg.max_span});
				op_b = MUL_W'({1'b0, cfg.max_span});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			rsp     <= '0;
		end else begin
			rsp.done <= (state_q == U_CMP);
			case (state_q)
				U_IDLE: if (req.start) state_q <= U_DIFF;
				U_DIFF: state_q <= U_MX;
				U_MX:   state_q <= U_MY;
				U_MY:   state_q <= U_SX;
				U_SX:   state_q <= U_SY;
				U_SY:   state_q <= U_LO;
				U_LO:   state_q <= U_HI;
				U_HI:   state_q <= U_CMP;
				U_CMP: begin
					rsp.ok   <= lo_ok_q && (sum_q <= prod_lo);
					state_q  <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a * op_b);
		if (state_q == U_IDLE && req.start) begin
			a1_q <= req.a1;
			a2_q <= req.a2;
		end
		if (state_q == U_DIFF) begin
			ds_q <= ds_d;
			dc_q <= dc_d;
		end
		if (state_q == U_MY) dx_q <= piv_ext + rnd;
		if (state_q == U_SX) dy_q <= rnd;
		if (state_q == U_SY) sum_q <= prod_lo;
		if (state_q == U_LO) sum_q <= sum_q + prod_lo;
		if (state_q == U_HI) lo_ok_q <= (sum_q >= prod_lo);
	end

endmodule

// ===== hdl/arm_span_angle_constraint_search_core.sv =====
// ----------------------------------------------------------------------------
// arm_span_angle_constraint_search_core
// Picks a permitted second servo angle so that the arm tip span stays in range.
// ----------------------------------------------------------------------------
// Usage
//   cmd    : item of first_angle and wanted_second_angle (degrees, clamped to
//            180). Taken when cmd.valid and cmd.ready meet at a clock edge.
//   result : item of second_angle and outcome (kept, moved, fallback).
//   cfg_we / cfg_index / cfg_data : write tip_reach (pivot to tip),
//            pivot_separation, min_span, max_span (Q8.8 cm). Write only while
//            the block is idle.
// Timing
//   One item at a time. Each candidate angle goes through the shared span
//   unit in turn (hand-off, table look-up, six passes of its one 19x19
//   multiplier, compare, answer), up to n candidates (n = 1 + |want - 90| / 2
//   rounded down, up to 46). The result goes to the output register before
//   the next item can be taken. cmd.ready is high only while the block is
//   idle.
// Reset
//   arst_n clears the sequencers and the output valid, and loads the
//   registers with their reset values. No clearing pass is needed.
// Stall
//   A finished result waits in the output register; a new item may be taken
//   meanwhile, and a second finished result holds until the first is taken.
// ----------------------------------------------------------------------------
module arm_span_angle_constraint_search_core #(
	parameter int TRIG_FRAC_BITS = ascs_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ascs_cmd_if.sink    cmd,
	ascs_rsl_if.source  result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ascs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE, S_SEARCH, S_HOLD
	} state_t;

	state_t     state_q;
	cfg_t       cfg_q;
	logic       start_q;
	span_req_t  span_req;
	span_rsp_t  rsp;

	// Search bookkeeping
	logic [7:0] a1_q;
	logic [7:0] cand_q;
	logic [6:0] off_q;     // remaining distance from centre
	logic       above_q;
	logic       first_q;

	// Finished result waiting for the output register
	logic [7:0] pend_angle_q;
	outcome_t   pend_outcome_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_angle_q;
	outcome_t   out_outcome_q;

	logic [7:0] a1_sat, want_sat;
	logic [6:0] off_next;
	logic       out_free;

	assign a1_sat   = sat_angle(cmd.first_angle);
	assign want_sat = sat_angle(cmd.wanted_second_angle);
	assign off_next = off_q - SEARCH_STEP;
	assign out_free = !out_valid_q || result.ready;

	assign cmd.ready           = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.second_angle = out_angle_q;
	assign result.outcome      = out_outcome_q;

	// Configuration registers: unknown indexes cannot occur with a 2-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tip_reach        <= TIP_REACH_RST;
			cfg_q.pivot_separation <= PIVOT_SEPARATION_RST;
			cfg_q.min_span         <= MIN_SPAN_RST;
			cfg_q.max_span         <= MAX_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIP_REACH:        cfg_q.tip_reach        <= cfg_data;
				REG_PIVOT_SEPARATION: cfg_q.pivot_separation <= cfg_data;
				REG_MIN_SPAN:         cfg_q.min_span         <= cfg_data;
				REG_MAX_SPAN:         cfg_q.max_span         <= cfg_data;
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Search sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// start a test on a new item, or advance one step toward centre
			// after a failed test and test again
			start_q <= (state_q == S_IDLE && cmd.valid) ||
				(state_q == S_SEARCH && rsp.done && !rsp.ok && off_q >= SEARCH_STEP);
			// load the output item, else drop it once it is taken
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					// stop on a pass, or once no step toward centre is left
					if (rsp.done && (rsp.ok || off_q < SEARCH_STEP)) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Search payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			a1_q    <= a1_sat;
			cand_q  <= want_sat;
			above_q <= (want_sat >= CENTRE_DEG);
			off_q   <= (want_sat >= CENTRE_DEG) ? 7'(want_sat - CENTRE_DEG)
			                                    : 7'(CENTRE_DEG - want_sat);
			first_q <= 1'b1;
		end
		if (state_q == S_SEARCH && rsp.done) begin
			if (rsp.ok) begin
				pend_angle_q   <= cand_q;
				pend_outcome_q <= first_q ? OUTCOME_KEPT : OUTCOME_MOVED;
			end else if (off_q < SEARCH_STEP) begin
				pend_angle_q   <= CENTRE_DEG;
				pend_outcome_q <= OUTCOME_FALLBACK;
			end else begin
				off_q   <= off_next;
				cand_q  <= above_q ? CENTRE_DEG + {1'b0, off_next}
				                   : CENTRE_DEG - {1'b0, off_next};
				first_q <= 1'b0;
			end
		end
		if (state_q == S_HOLD && out_free) begin
			out_angle_q   <= pend_angle_q;
			out_outcome_q <= pend_outcome_q;
		end
	end

	// Candidate angles for the span unit
	assign span_req = '{start: start_q, a1: a1_q, a2: cand_q};

	ascs_span_unit #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_span (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (span_req),
		.rsp    (rsp)
	);

	// A span answer only arrives while a search is running
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_SEARCH)
		else $error("span answer outside a search");

	// A fallback result always carries the centre angle
	a_fallback_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.outcome == OUTCOME_FALLBACK) |->
		result.second_angle == CENTRE_DEG)
		else $error("fallback result not at centre");

	// A taken item starts a search and a test request
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == S_SEARCH && start_q))
		else $error("taken item did not start a search");

endmodule

// ===== tb/sv/tb_arm_span_angle_constraint_search_core.sv =====
// ----------------------------------------------------------------------------
// tb_arm_span_angle_constraint_search_core
// Self-checking bench for the arm span angle search: a directed table, then
// random angle pairs under several geometries, each result checked against a
// typed row or a bit-exact predictor of the fixed-point span test and search.
// ----------------------------------------------------------------------------
module tb_arm_span_angle_constraint_search_core;
	import ascs_pkg::*;

	// Search constants as plain integers for the predictor arithmetic
	localparam int CENTRE = CENTRE_DEG;
	localparam int TOP    = TOP_DEG;
	localparam int STEP   = SEARCH_STEP;
	localparam int TRIG   = TRIG_FRAC_BITS_DEF;

	// Worst case search: 46 candidates, plus a margin
	localparam int SETTLE_CYCLES = 480;

	typedef struct packed {
		logic [7:0] angle;
		outcome_t   outcome;
	} choice_t;

	typedef struct {
		int         setting;
		logic [7:0] first;
		logic [7:0] want;
		bit         typed;
		logic [7:0] exp_angle;
		outcome_t   exp_outcome;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	ascs_cmd_if cmd_ch ();
	ascs_rsl_if rsl_ch ();

	arm_span_angle_constraint_search_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (rsl_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Geometry as the block should currently hold it
	cfg_t    geom = '{TIP_REACH_RST, PIVOT_SEPARATION_RST, MIN_SPAN_RST, MAX_SPAN_RST};
	choice_t pending_choices [$];
	int      mismatches = 0;
	bit      calm = 1'b1;
	int      hold_cnt = 0;

	// Geometries used by the directed table; setting 0 keeps the reset values
	cfg_t presets [0:3] = '{
		'{TIP_REACH_RST, PIVOT_SEPARATION_RST, MIN_SPAN_RST, MAX_SPAN_RST},
		'{TIP_REACH_RST, PIVOT_SEPARATION_RST, 16'hFFFF, 16'h0000},
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}
	};

	// Equal angles leave the span at the pivot separation, which the reset
	// geometry accepts; a minimum above the maximum forces the fallback; an
	// all-zero geometry accepts everything.
	row_t plan [0:20] = '{
		'{0,  8'd90,  8'd90, 1'b1,  8'd90, OUTCOME_KEPT},
		'{0,   8'd0,   8'd0, 1'b1,   8'd0, OUTCOME_KEPT},
		'{0, 8'd180, 8'd180, 1'b1, 8'd180, OUTCOME_KEPT},
		'{0, 8'd255, 8'd255, 1'b1, 8'd180, OUTCOME_KEPT},
		'{0, 8'd200, 8'd250, 1'b1, 8'd180, OUTCOME_KEPT},
		'{0,  8'd45,  8'd45, 1'b1,  8'd45, OUTCOME_KEPT},
		'{0,   8'd0, 8'd180, 1'b0,   8'd0, OUTCOME_KEPT},
		'{0, 8'd180,   8'd0, 1'b0,   8'd0, OUTCOME_KEPT},
		'{0,   8'd0,   8'd1, 1'b0,   8'd0, OUTCOME_KEPT},
		'{0, 8'd180, 8'd179, 1'b0,   8'd0, OUTCOME_KEPT},
		'{0,  8'd90,   8'd0, 1'b0,   8'd0, OUTCOME_KEPT},
		'{0,   8'd0, 8'd255, 1'b0,   8'd0, OUTCOME_KEPT},
		'{1,  8'd90,  8'd90, 1'b1,  8'd90, OUTCOME_FALLBACK},
		'{1,   8'd0,   8'd1, 1'b1,  8'd90, OUTCOME_FALLBACK},
		'{1, 8'd255, 8'd180, 1'b1,  8'd90, OUTCOME_FALLBACK},
		'{2,   8'd0, 8'd180, 1'b1, 8'd180, OUTCOME_KEPT},
		'{2, 8'd180,   8'd0, 1'b1,   8'd0, OUTCOME_KEPT},
		'{2,  8'd37, 8'd142, 1'b1, 8'd142, OUTCOME_KEPT},
		'{3,   8'd0, 8'd180, 1'b0,   8'd0, OUTCOME_KEPT},
		'{3, 8'd180,   8'd0, 1'b0,   8'd0, OUTCOME_KEPT},
		'{3,  8'd90,  8'd90, 1'b0,   8'd0, OUTCOME_KEPT}
	};

	// ------------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Table sine of 0..90 degrees, rescaled to the trig fraction width
	function automatic longint trig_at(int deg);
		longint v;
		int     dn;
		v = longint'(SINE_Q15[(deg > 90) ? 90 : deg]);
		if (TRIG >= TABLE_FRAC) begin
			v = v <<< (TRIG - TABLE_FRAC);
		end else begin
			dn = TABLE_FRAC - TRIG;
			v = (v + (64'sd1 <<< (dn - 1))) >>> dn;
		end
		return v;
	endfunction

	function automatic longint sine_of(int a);
		return (a <= 90) ? trig_at(a) : trig_at(180 - a);
	endfunction

	function automatic longint cosine_of(int a);
		return (a <= 90) ? trig_at(90 - a) : -trig_at(a - 90);
	endfunction

	// Drop the trig fraction bits, rounding half toward plus infinity
	function automatic longint drop_frac(longint x);
		return (x + (64'sd1 <<< (TRIG - 1))) >>> TRIG;
	endfunction

	// Squared tip-to-tip span against the squared limits, exactly
	function automatic bit span_in_range(int a1, int a2);
		longint len, dx, dy, sq, lo, hi;
		len = longint'(geom.tip_reach);
		dx  = longint'(geom.pivot_separation) + drop_frac(len * (sine_of(a2) - sine_of(a1)));
		dy  = drop_frac(len * (cosine_of(a1) - cosine_of(a2)));
		sq  = dx * dx + dy * dy;
		lo  = longint'(geom.min_span) * longint'(geom.min_span);
		hi  = longint'(geom.max_span) * longint'(geom.max_span);
		return (sq >= lo) && (sq <= hi);
	endfunction

	// Keep the wanted angle, else walk toward the centre in steps, else
	// fall back to the centre
	function automatic choice_t choose_second_angle(logic [7:0] first, logic [7:0] want);
		choice_t c;
		int      a1, w, off, t, cand;
		bit      above, found;
		a1 = (int'(first) > TOP) ? TOP : int'(first);
		w  = (int'(want) > TOP) ? TOP : int'(want);
		c.angle   = CENTRE[7:0];
		c.outcome = OUTCOME_FALLBACK;
		if (span_in_range(a1, w)) begin
			c.angle   = w[7:0];
			c.outcome = OUTCOME_KEPT;
		end else begin
			off   = w - CENTRE;
			above = (off >= 0);
			if (off < 0) off = -off;
			found = 1'b0;
			for (t = off; t >= 0 && !found; t -= STEP) begin
				cand = above ? CENTRE + t : CENTRE - t;
				if (cand < 0) cand = 0;
				if (cand > TOP) cand = TOP;
				if (span_in_range(a1, cand)) begin
					c.angle   = cand[7:0];
					c.outcome = OUTCOME_MOVED;
					found     = 1'b1;
				end
			end
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// Mostly legal angles, some corners, some beyond 180
	function automatic logic [7:0] pick_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 8'($urandom_range(181, 255));
		if (r < 20) begin
			case ($urandom_range(0, 6))
				0: return 8'd0;
				1: return 8'd1;
				2: return 8'd89;
				3: return 8'd90;
				4: return 8'd91;
				5: return 8'd179;
				default: return 8'd180;
			endcase
		end
		return 8'($urandom_range(0, 180));
	endfunction

	// Called at a falling edge; returns at a falling edge
	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	task automatic load_geometry(cfg_t g);
		write_reg(REG_TIP_REACH, g.tip_reach);
		write_reg(REG_PIVOT_SEPARATION, g.pivot_separation);
		write_reg(REG_MIN_SPAN, g.min_span);
		write_reg(REG_MAX_SPAN, g.max_span);
		cfg_we <= 1'b0;
		geom = g;
		@(negedge clk);
	endtask

	// Hold until every expected result has been taken, then let it settle
	task automatic wait_idle();
		while (pending_choices.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Offer one item after a gap; called and returns at a falling edge.
	// A typed expectation, where given, replaces the predictor.
	task automatic offer_item(logic [7:0] first, logic [7:0] want, int gap,
		bit typed, choice_t typed_choice);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid               <= 1'b1;
		cmd_ch.first_angle         <= first;
		cmd_ch.wanted_second_angle <= want;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_choices.push_back(typed ? typed_choice : choose_second_angle(first, want));
		@(negedge clk);
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall at random, check each item taken
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			rsl_ch.ready <= 1'b0;
			hold_cnt--;
		end else begin
			rsl_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) < 3) begin
				hold_cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 50);
			end
		end
	end

	always @(posedge clk) begin
		choice_t want_c;
		if (arst_n && rsl_ch.valid && rsl_ch.ready) begin
			if (pending_choices.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d with nothing expected",
					rsl_ch.second_angle, rsl_ch.outcome));
			end else begin
				want_c = pending_choices.pop_front();
				if (rsl_ch.second_angle !== want_c.angle) begin
					report_mismatch($sformatf("second_angle %0d, expected %0d",
						rsl_ch.second_angle, want_c.angle));
				end
				if (rsl_ch.outcome !== want_c.outcome) begin
					report_mismatch($sformatf("outcome %0d, expected %0d",
						rsl_ch.outcome, want_c.outcome));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int      cur_setting;
		int      phase;
		int      n;
		cfg_t    g;
		choice_t typed_c;

		// Drive every input to a known value and hold reset, then release it
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_index                  = REG_TIP_REACH;
		cfg_data                   = '0;
		cmd_ch.valid               = 1'b0;
		cmd_ch.first_angle         = '0;
		cmd_ch.wanted_second_angle = '0;
		rsl_ch.ready               = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: switch geometry only once the block has gone idle
		cur_setting = 0;
		foreach (plan[i]) begin
			if (plan[i].setting != cur_setting) begin
				cmd_ch.valid <= 1'b0;
				wait_idle();
				load_geometry(presets[plan[i].setting]);
				cur_setting = plan[i].setting;
			end
			typed_c.angle   = plan[i].exp_angle;
			typed_c.outcome = plan[i].exp_outcome;
			offer_item(plan[i].first, plan[i].want, 0, plan[i].typed, typed_c);
		end

		// Random part: one geometry per phase: the reset one, two extremes, then random ones
		for (phase = 0; phase < 7; phase++) begin
			cmd_ch.valid <= 1'b0;
			wait_idle();
			case (phase)
				0: g = presets[0];
				1: g = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
				2: g = '{16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				6: g = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
				default: begin
					g.tip_reach        = 16'($urandom_range(512, 8192));
					g.pivot_separation = 16'($urandom_range(0, 16384));
					g.min_span         = 16'($urandom_range(0, 6000));
					g.max_span         = 16'(int'(g.min_span) + $urandom_range(0, 16000));
				end
			endcase
			load_geometry(g);
			for (n = 0; n < 100; n++) begin
				// Alternate stretches with and without idling
				if (n % 25 == 0) calm = (phase == 0) || ($urandom_range(0, 3) == 0);
				offer_item(pick_angle(), pick_angle(), pick_gap(), 1'b0, typed_c);
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain, then watch for strays for the longest search time
		while (pending_choices.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
